// ===== rtl/core/tsag_pkg.sv =====
// shared types and constants for the tensor slice address generator
package tsag_pkg;

  localparam int unsigned DIMS   = 4;
  localparam int unsigned EXT_W  = 16;
  localparam int unsigned IDX_W  = 32;
  localparam int unsigned DIM_W  = $clog2(DIMS) > 0 ? $clog2(DIMS) : 1;
  localparam int unsigned STEPS  = IDX_W + 1;
  localparam int unsigned NCELLS = DIMS * STEPS;

  typedef enum logic [1:0] {
    REG_NUM_DIMS      = 2'd0,
    REG_IN_EXTENTS    = 2'd1,
    REG_OUT_EXTENTS   = 2'd2,
    REG_START_OFFSETS = 2'd3
  } tsag_reg_e;

  typedef struct packed {
    logic [IDX_W-1:0] idx;
    logic [IDX_W-1:0] qr;
    logic [EXT_W-1:0] rem;
    logic [IDX_W-1:0] addr;
    logic [IDX_W-1:0] stride;
  } tsag_beat_t;

endpackage

// ===== rtl/core/tsag_div_cell.sv =====
// one restoring division step of the coordinate split
module tsag_div_cell import tsag_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             valid_i,
  input  tsag_beat_t       beat_i,
  input  logic [EXT_W-1:0] ext_i,
  output logic             valid_o,
  output tsag_beat_t       beat_o
);

  logic [EXT_W:0]   trial;
  logic [EXT_W:0]   ext_x;
  logic             qbit;
  tsag_beat_t       beat_d;
  tsag_beat_t       beat_q;
  logic             valid_q;

  assign trial = {beat_i.rem, beat_i.qr[IDX_W-1]};
  assign ext_x = {1'b0, ext_i};

  always_comb begin
    beat_d = beat_i;
    qbit   = 1'b0;
    if (ext_i == '0) begin
      // zero extent: dividend passes on untouched
      qbit       = beat_i.qr[IDX_W-1];
      beat_d.rem = '0;
    end else if (trial >= ext_x) begin
      qbit       = 1'b1;
      beat_d.rem = EXT_W'(trial - ext_x);
    end else begin
      beat_d.rem = trial[EXT_W-1:0];
    end
    beat_d.qr = {beat_i.qr[IDX_W-2:0], qbit};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    beat_q <= beat_d;
  end

  assign valid_o = valid_q;
  assign beat_o  = beat_q;

endmodule

// ===== rtl/core/tsag_mac_cell.sv =====
// offset, stride weighting and accumulation for one dimension
module tsag_mac_cell import tsag_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             valid_i,
  input  tsag_beat_t       beat_i,
  input  logic             active_i,
  input  logic [EXT_W-1:0] in_ext_i,
  input  logic [EXT_W-1:0] offset_i,
  output logic             valid_o,
  output tsag_beat_t       beat_o
);

  logic [EXT_W:0]   coord;
  logic [IDX_W-1:0] term;
  logic [IDX_W-1:0] stride_n;
  tsag_beat_t       beat_d;
  tsag_beat_t       beat_q;
  logic             valid_q;

  assign coord    = {1'b0, beat_i.rem} + {1'b0, offset_i};
  assign term     = IDX_W'(coord) * beat_i.stride;
  assign stride_n = beat_i.stride * IDX_W'(in_ext_i);

  always_comb begin
    beat_d     = beat_i;
    beat_d.rem = '0;
    if (active_i) begin
      beat_d.addr   = beat_i.addr + term;
      beat_d.stride = stride_n;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    beat_q <= beat_d;
  end

  assign valid_o = valid_q;
  assign beat_o  = beat_q;

endmodule

// ===== rtl/core/tensor_slice_address_gen.sv =====
// top level: slice index to source address, a chain of division and accumulate cells
// One index is taken every cycle (busy stays low); its result appears on
// valid_o after passing the chain of 32 one-bit division cells plus one
// accumulate cell per dimension, each cell a register stage. Results
// cannot be held off and leave in input order. Configuration is taken at once
// (cfg_ready_o high) and must only be written while no index is in flight.
module tensor_slice_address_gen import tsag_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start,
  output logic             busy,
  input  logic [IDX_W-1:0] out_index_i,
  output logic             valid_o,
  output logic [IDX_W-1:0] dest_index_o,
  output logic [IDX_W-1:0] source_index_o,
  input  logic             cfg_valid_i,
  output logic             cfg_ready_o,
  input  logic [1:0]       cfg_index_i,
  input  logic [63:0]      cfg_data_i
);

  logic [2:0]  num_dims_q;
  logic [63:0] in_ext_q;
  logic [63:0] out_ext_q;
  logic [63:0] offs_q;

  logic [DIM_W:0]   n_dims;
  logic [EXT_W-1:0] st_out_ext [DIMS];
  logic [EXT_W-1:0] st_in_ext  [DIMS];
  logic [EXT_W-1:0] st_off     [DIMS];
  logic             st_act     [DIMS];

  tsag_beat_t chain_beat  [NCELLS+1];
  logic       chain_valid [NCELLS+1];
  logic       accept;

  assign busy        = 1'b0;
  assign cfg_ready_o = 1'b1;
  assign accept      = start && !busy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_dims_q <= 3'd1;
      in_ext_q   <= 64'h0001_0001_0001_0001;
      out_ext_q  <= 64'h0001_0001_0001_0001;
      offs_q     <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (tsag_reg_e'(cfg_index_i))
        REG_NUM_DIMS:      num_dims_q <= cfg_data_i[2:0];
        REG_IN_EXTENTS:    in_ext_q   <= cfg_data_i;
        REG_OUT_EXTENTS:   out_ext_q  <= cfg_data_i;
        REG_START_OFFSETS: offs_q     <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // clamp dimension count, then map chain stage k to dimension n-1-k
  always_comb begin
    logic [DIM_W-1:0] d;
    if (num_dims_q == 3'd0) begin
      n_dims = (DIM_W+1)'(1);
    end else if (32'(num_dims_q) > DIMS) begin
      n_dims = (DIM_W+1)'(DIMS);
    end else begin
      n_dims = (DIM_W+1)'(num_dims_q);
    end
    for (int k = 0; k < DIMS; k++) begin
      d             = DIM_W'(n_dims - (DIM_W+1)'(1) - (DIM_W+1)'(k));
      st_act[k]     = (DIM_W+1)'(k) < n_dims;
      st_out_ext[k] = out_ext_q[d*EXT_W +: EXT_W];
      st_in_ext[k]  = in_ext_q[d*EXT_W +: EXT_W];
      st_off[k]     = offs_q[d*EXT_W +: EXT_W];
    end
  end

  always_comb begin
    chain_valid[0]       = accept;
    chain_beat[0].idx    = out_index_i;
    chain_beat[0].qr     = out_index_i;
    chain_beat[0].rem    = '0;
    chain_beat[0].addr   = '0;
    chain_beat[0].stride = IDX_W'(1);
  end

  for (genvar k = 0; k < DIMS; k++) begin : g_dim
    for (genvar j = 0; j < IDX_W; j++) begin : g_div
      tsag_div_cell u_div (
        .clk_i   (clk_i),
        .rst_ni  (rst_ni),
        .valid_i (chain_valid[k*STEPS+j]),
        .beat_i  (chain_beat[k*STEPS+j]),
        .ext_i   (st_out_ext[k]),
        .valid_o (chain_valid[k*STEPS+j+1]),
        .beat_o  (chain_beat[k*STEPS+j+1])
      );
    end
    tsag_mac_cell u_mac (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .valid_i  (chain_valid[k*STEPS+IDX_W]),
      .beat_i   (chain_beat[k*STEPS+IDX_W]),
      .active_i (st_act[k]),
      .in_ext_i (st_in_ext[k]),
      .offset_i (st_off[k]),
      .valid_o  (chain_valid[(k+1)*STEPS]),
      .beat_o   (chain_beat[(k+1)*STEPS])
    );
  end

  assign valid_o        = chain_valid[NCELLS];
  assign dest_index_o   = chain_beat[NCELLS].idx;
  assign source_index_o = chain_beat[NCELLS].addr;

  a_latency : assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> $past(accept, NCELLS))
    else $error("result beat without matching input beat");

  a_no_loss : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(accept, NCELLS) && $past(rst_ni, NCELLS) |-> valid_o)
    else $error("input beat lost in chain");

  a_mid_chain : assert property (@(posedge clk_i) disable iff (!rst_ni)
    chain_valid[STEPS] |=> chain_valid[STEPS+1])
    else $error("beat dropped between dimension cells");

endmodule

// ===== dv/tsag_checker.sv =====
// checker: predicts source addresses from the observed config and compares results
module tsag_checker import tsag_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic             busy_i,
  input  logic [IDX_W-1:0] out_index_i,
  input  logic             valid_i,
  input  logic [IDX_W-1:0] dest_index_i,
  input  logic [IDX_W-1:0] source_index_i,
  input  logic             cfg_valid_i,
  input  logic             cfg_ready_i,
  input  logic [1:0]       cfg_index_i,
  input  logic [63:0]      cfg_data_i,
  output int               pending_o,
  output int               errors_o
);

  typedef struct {
    logic [IDX_W-1:0] dest;
    logic [IDX_W-1:0] source;
  } addr_pair_t;

  logic [2:0]  num_dims_q;
  logic [63:0] in_ext_q;
  logic [63:0] out_ext_q;
  logic [63:0] offsets_q;
  addr_pair_t  expected_addrs[$];
  int          errors_q;

  function automatic logic [IDX_W-1:0] gather_addr(logic [IDX_W-1:0] idx);
    int               n;
    logic [IDX_W-1:0] rest;
    logic [IDX_W-1:0] coord[DIMS];
    logic [IDX_W-1:0] stride;
    logic [IDX_W-1:0] addr;
    logic [IDX_W-1:0] ext;
    logic [IDX_W-1:0] c;
    n = (num_dims_q == 0) ? 1 : (num_dims_q > DIMS) ? DIMS : int'(num_dims_q);
    rest = idx;
    for (int d = n - 1; d >= 0; d--) begin
      ext = {16'b0, out_ext_q[16*d +: 16]};
      if (ext == 0) begin
        coord[d] = '0;
      end else begin
        coord[d] = rest % ext;
        rest = rest / ext;
      end
    end
    stride = 1;
    addr = '0;
    for (int d = n - 1; d >= 0; d--) begin
      c = coord[d] + {16'b0, offsets_q[16*d +: 16]};
      addr = addr + c * stride;
      stride = stride * {16'b0, in_ext_q[16*d +: 16]};
    end
    return addr;
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    addr_pair_t exp_pair;
    int         miss;
    if (!rst_ni) begin
      num_dims_q <= 3'd1;
      in_ext_q   <= 64'h0001_0001_0001_0001;
      out_ext_q  <= 64'h0001_0001_0001_0001;
      offsets_q  <= '0;
      errors_q   <= 0;
    end else begin
      miss = 0;
      if (cfg_valid_i && cfg_ready_i) begin
        case (tsag_reg_e'(cfg_index_i))
          REG_NUM_DIMS:      num_dims_q <= cfg_data_i[2:0];
          REG_IN_EXTENTS:    in_ext_q   <= cfg_data_i;
          REG_OUT_EXTENTS:   out_ext_q  <= cfg_data_i;
          REG_START_OFFSETS: offsets_q  <= cfg_data_i;
          default: ;
        endcase
      end
      if (start_i && !busy_i) begin
        exp_pair.dest   = out_index_i;
        exp_pair.source = gather_addr(out_index_i);
        expected_addrs  = {expected_addrs, exp_pair};
      end
      if (valid_i) begin
        if (expected_addrs.size() == 0) begin
          $error("unexpected result beat: dest %h source %h", dest_index_i, source_index_i);
          miss = miss + 1;
        end else begin
          exp_pair = expected_addrs.pop_front();
          if (dest_index_i !== exp_pair.dest) begin
            $error("dest_index: expected %h actual %h", exp_pair.dest, dest_index_i);
            miss = miss + 1;
          end
          if (source_index_i !== exp_pair.source) begin
            $error("source_index: expected %h actual %h", exp_pair.source, source_index_i);
            miss = miss + 1;
          end
        end
      end
      errors_q <= errors_q + miss;
    end
  end

  assign pending_o = expected_addrs.size();
  assign errors_o  = errors_q;

endmodule

// ===== dv/tensor_slice_address_gen_tb.sv =====
// testbench top: drives indices and config writes, gives the verdict
module tensor_slice_address_gen_tb;
  import tsag_pkg::*;

  localparam int DRAIN_CYCLES = 140;
  localparam int STALL_LIMIT  = 3000;

  logic             clk;
  logic             rst_n;
  logic             start;
  logic             busy;
  logic [IDX_W-1:0] out_index;
  logic             valid;
  logic [IDX_W-1:0] dest_index;
  logic [IDX_W-1:0] source_index;
  logic             cfg_valid;
  logic             cfg_ready;
  logic [1:0]       cfg_index;
  logic [63:0]      cfg_data;
  int               pending;
  int               errors;
  int               stall_cnt = 0;
  bit               no_gaps;
  longint unsigned  index_span;

  tensor_slice_address_gen u_dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .start          (start),
    .busy           (busy),
    .out_index_i    (out_index),
    .valid_o        (valid),
    .dest_index_o   (dest_index),
    .source_index_o (source_index),
    .cfg_valid_i    (cfg_valid),
    .cfg_ready_o    (cfg_ready),
    .cfg_index_i    (cfg_index),
    .cfg_data_i     (cfg_data)
  );

  tsag_checker u_checker (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .start_i        (start),
    .busy_i         (busy),
    .out_index_i    (out_index),
    .valid_i        (valid),
    .dest_index_i   (dest_index),
    .source_index_i (source_index),
    .cfg_valid_i    (cfg_valid),
    .cfg_ready_i    (cfg_ready),
    .cfg_index_i    (cfg_index),
    .cfg_data_i     (cfg_data),
    .pending_o      (pending),
    .errors_o       (errors)
  );

  initial clk = 1'b0;
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    if ((start && !busy) || valid || (cfg_valid && cfg_ready)) begin
      stall_cnt <= 0;
    end else begin
      stall_cnt <= stall_cnt + 1;
    end
    if (stall_cnt >= STALL_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  function automatic int gap_len();
    int r;
    if (no_gaps) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 50);
  endfunction

  task automatic send_index(logic [IDX_W-1:0] idx);
    int  gap;
    bit  ok;
    gap = gap_len();
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start     <= 1'b1;
    out_index <= idx;
    do begin
      @(negedge clk);
      ok = !busy;
      @(posedge clk);
    end while (!ok);
  endtask

  task automatic write_reg(tsag_reg_e idx, logic [63:0] data);
    bit ok;
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do begin
      @(negedge clk);
      ok = cfg_ready;
      @(posedge clk);
    end while (!ok);
    cfg_valid <= 1'b0;
  endtask

  task automatic settle();
    start <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic setup(logic [2:0] nd, logic [63:0] in_ext, logic [63:0] out_ext,
                       logic [63:0] offs);
    longint unsigned span;
    int              n;
    settle();
    write_reg(REG_NUM_DIMS, {61'b0, nd});
    write_reg(REG_IN_EXTENTS, in_ext);
    write_reg(REG_OUT_EXTENTS, out_ext);
    write_reg(REG_START_OFFSETS, offs);
    n = (nd == 0) ? 1 : (nd > DIMS) ? DIMS : nd;
    span = 1;
    for (int d = 0; d < n; d++) begin
      if (out_ext[16*d +: 16] != 0) span = span * out_ext[16*d +: 16];
    end
    index_span = span;
  endtask

  function automatic logic [15:0] rand_extent();
    int r;
    r = $urandom_range(0, 99);
    if (r < 8) return 16'd0;
    if (r < 14) return 16'hffff;
    if (r < 22) return 16'($urandom);
    return 16'($urandom_range(1, 20));
  endfunction

  function automatic logic [63:0] rand_packed(bit is_offset);
    logic [63:0] v;
    for (int d = 0; d < DIMS; d++) begin
      if (is_offset) begin
        v[16*d +: 16] = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 10));
      end else begin
        v[16*d +: 16] = rand_extent();
      end
    end
    return v;
  endfunction

  initial begin
    logic [IDX_W-1:0] idx;
    rst_n     = 1'b0;
    start     = 1'b0;
    out_index = '0;
    cfg_valid = 1'b0;
    cfg_index = REG_NUM_DIMS;
    cfg_data  = '0;
    no_gaps   = 1'b0;
    index_span = 1;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset config: single dimension of extent one
    send_index(32'd0);
    send_index(32'hffff_ffff);
    send_index(32'h1234_5678);

    // four dims, small extents, index past the end wraps outermost
    setup(3'd4, 64'h0005_0004_0003_0002, 64'h0003_0002_0002_0002,
          64'h0001_0001_0000_0001);
    send_index(32'd0);
    send_index(32'd23);
    send_index(32'd24);
    send_index(32'hffff_ffff);

    // zero dims acts as one, zero slice extents
    setup(3'd0, 64'h0000_0000_0000_0000, 64'h0000_0000_0000_0000, 64'h0);
    send_index(32'h8000_0000);
    send_index(32'd7);

    // too many dims acts as four, max extents and offsets, address wraps
    setup(3'd7, 64'hffff_ffff_ffff_ffff, 64'hffff_ffff_ffff_ffff,
          64'hffff_ffff_ffff_ffff);
    send_index(32'd0);
    send_index(32'hffff_ffff);
    send_index(32'h5555_aaaa);
    send_index(32'haaaa_5555);

    // mixed zero and nonzero slice extents
    setup(3'd3, 64'h0000_0007_0000_0009, 64'h0000_0003_0000_0005,
          64'h0000_0002_ffff_0000);
    send_index(32'd14);
    send_index(32'd15);
    send_index(32'hffff_fffe);

    for (int phase = 0; phase < 10; phase++) begin
      setup(3'($urandom_range(0, 7)), rand_packed(1'b0), rand_packed(1'b0),
            rand_packed(1'b1));
      no_gaps = ($urandom_range(0, 3) == 0);
      for (int i = 0; i < 110; i++) begin
        if ($urandom_range(0, 99) < 70) begin
          idx = 32'($urandom_range(0, 32'(index_span > 64'hffff_ffff ? 64'hffff_ffff
                                                                     : index_span - 1)));
        end else begin
          idx = $urandom;
        end
        send_index(idx);
      end
    end
    no_gaps = 1'b0;

    settle();
    if (errors == 0 && pending == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
